[rtl/hwn_pkg.sv]
// Shared types and constants for the height window to normal RGB core.
package hwn_pkg;

   localparam int NUM_LANES = 8;
   localparam int HEIGHT_W  = 16;
   localparam int SCALE_W   = 32;
   localparam int SLOPE_W   = HEIGHT_W + SCALE_W;
   localparam int RED_W     = 30;
   localparam int SUMSQ_W   = 2 * RED_W + 2;
   localparam int ROOT_W    = SUMSQ_W / 2;
   localparam int BYTE_W    = 8;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;
   localparam logic [SLOPE_W-1:0] Z_EDGE      = 48'h0000_0100_0000;
   localparam logic [SLOPE_W-1:0] Z_DIAG      = 48'h0000_0200_0000;

   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   // Neighbor slots of the slope stage.
   localparam int NB_W  = 0;
   localparam int NB_E  = 1;
   localparam int NB_N  = 2;
   localparam int NB_S  = 3;
   localparam int NB_NW = 4;
   localparam int NB_NE = 5;
   localparam int NB_SW = 6;
   localparam int NB_SE = 7;

   typedef struct packed {
      logic [HEIGHT_W-1:0] center_height;
      logic [HEIGHT_W-1:0] west_height;
      logic [HEIGHT_W-1:0] east_height;
      logic [HEIGHT_W-1:0] north_height;
      logic [HEIGHT_W-1:0] south_height;
      logic [HEIGHT_W-1:0] northwest_height;
      logic [HEIGHT_W-1:0] northeast_height;
      logic [HEIGHT_W-1:0] southwest_height;
      logic [HEIGHT_W-1:0] southeast_height;
   } req_data_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red_byte;
      logic [BYTE_W-1:0] green_byte;
      logic [BYTE_W-1:0] blue_byte;
   } rsp_data_type;

endpackage

[rtl/hwn_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
module hwn_isqrt #(
   parameter int IN_W   = 62,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     radicand,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int RW    = IN_W / 2;
   localparam int REM_W = RW + 2;

   logic              v_ff    [RW];
   logic [IN_W-1:0]   rad_ff  [RW];
   logic [REM_W-1:0]  rem_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [SIDE_W-1:0] side_ff [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      logic              prev_v;
      logic [IN_W-1:0]   prev_rad;
      logic [REM_W-1:0]  prev_rem;
      logic [RW-1:0]     prev_root;
      logic [SIDE_W-1:0] prev_side;
      logic [REM_W-1:0]  rem_t;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [RW-1:0]     root_in;

      if (s == 0) begin : g_first
         assign prev_v    = in_valid;
         assign prev_rad  = radicand;
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_side = in_side;
      end else begin : g_next
         assign prev_v    = v_ff[s-1];
         assign prev_rad  = rad_ff[s-1];
         assign prev_rem  = rem_ff[s-1];
         assign prev_root = root_ff[s-1];
         assign prev_side = side_ff[s-1];
      end

      always_comb begin
         rem_t = {prev_rem[RW-1:0], prev_rad[IN_W-1 -: 2]};
         trial = {prev_root, 2'b01};
         if (rem_t >= trial) begin
            rem_in  = rem_t - trial;
            root_in = {prev_root[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_t;
            root_in = {prev_root[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[s]  <= prev_rad << 2;
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            side_ff[s] <= prev_side;
         end
      end
   end

   assign out_valid = v_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

[rtl/hwn_div3.sv]
// Pipelined rounded divider for three components over a shared length.
module hwn_div3 #(
   parameter int MAG_W  = 30,
   parameter int DEN_W  = 31,
   parameter int Q_W    = 17,
   parameter int SIDE_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [2:0][MAG_W-1:0] num_mag,
   input  logic [DEN_W-1:0]      den,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [2:0][Q_W-1:0]   quo,
   output logic [SIDE_W-1:0]     out_side
);
   localparam int NUM_W = MAG_W + Q_W;
   localparam int REM_W = DEN_W + 1;

   logic                  v_ff    [Q_W+1];
   logic [2:0][REM_W-1:0] rem_ff  [Q_W+1];
   logic [2:0][Q_W-1:0]   low_ff  [Q_W+1];
   logic [2:0][Q_W-1:0]   q_ff    [Q_W+1];
   logic [DEN_W-1:0]      den_ff  [Q_W+1];
   logic [SIDE_W-1:0]     side_ff [Q_W+1];
   logic [2:0][NUM_W-1:0] num;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = NUM_W'({num_mag[i], {(Q_W-1){1'b0}}}) + NUM_W'(den >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= REM_W'(num[i] >> Q_W);
            low_ff[0][i] <= num[i][Q_W-1:0];
         end
         q_ff[0]    <= '0;
         den_ff[0]  <= den;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 1; s <= Q_W; s++) begin : g_stage
      logic [2:0][REM_W-1:0] rem_t;
      logic [2:0][REM_W-1:0] rem_in;
      logic [2:0][Q_W-1:0]   q_in;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rem_t[i] = {rem_ff[s-1][i][DEN_W-1:0], low_ff[s-1][i][Q_W-1]};
            if (rem_t[i] >= {1'b0, den_ff[s-1]}) begin
               rem_in[i] = rem_t[i] - {1'b0, den_ff[s-1]};
               q_in[i]   = {q_ff[s-1][i][Q_W-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_t[i];
               q_in[i]   = {q_ff[s-1][i][Q_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            for (int i = 0; i < 3; i++) begin
               low_ff[s][i] <= low_ff[s-1][i] << 1;
            end
            q_ff[s]    <= q_in;
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[Q_W];
   assign quo       = q_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule

[rtl/hwn_norm.sv]
// Vector normalizer: range reduction, square root and rounded divide.
module hwn_norm #(
   parameter int MAG_W  = 48,
   parameter int FRAC_W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [2:0][MAG_W-1:0]    in_mag,
   input  logic [2:0]               in_neg,
   output logic                     out_valid,
   output logic [2:0][FRAC_W+1:0]   out_unit
);
   import hwn_pkg::*;

   localparam int K_W    = $clog2(MAG_W + 1);
   localparam int Q_W    = FRAC_W + 1;
   localparam int U_W    = FRAC_W + 2;
   localparam int SIDE_W = 3 + 3 * RED_W;

   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic [MAG_W-1:0]        mxy_ff;
   logic [MAG_W-1:0]        m_ff;
   logic [2:0][MAG_W-1:0]   mag1_ff, mag2_ff, mag3_ff;
   logic [2:0]              neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [K_W-1:0]          k_ff;
   logic [K_W-1:0]          k_in;
   int                      msb;
   logic [2:0][RED_W-1:0]   red4_ff, red5_ff, red6_ff;
   logic [2:0][2*RED_W-1:0] sq5_ff;
   logic [SUMSQ_W-1:0]      sumsq_ff;
   logic                    sq_valid;
   logic [ROOT_W-1:0]       sq_root;
   logic [SIDE_W-1:0]       sq_side;
   logic                    dv_valid;
   logic [2:0][Q_W-1:0]     dv_quo;
   logic [3:0]              dv_side;
   logic [2:0][U_W-1:0]     unit_ff;

   always_comb begin
      msb = 0;
      for (int i = 0; i < MAG_W; i++) begin
         if (m_ff[i]) begin
            msb = i;
         end
      end
      if (msb >= RED_W) begin
         k_in = K_W'(msb - RED_W + 1);
      end else begin
         k_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mxy_ff  <= (in_mag[AXIS_X] > in_mag[AXIS_Y]) ? in_mag[AXIS_X] : in_mag[AXIS_Y];
         mag1_ff <= in_mag;
         neg1_ff <= in_neg;
         m_ff    <= (mxy_ff > mag1_ff[AXIS_Z]) ? mxy_ff : mag1_ff[AXIS_Z];
         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         k_ff    <= k_in;
         mag3_ff <= mag2_ff;
         neg3_ff <= neg2_ff;
         for (int i = 0; i < 3; i++) begin
            red4_ff[i] <= RED_W'(mag3_ff[i] >> k_ff);
            sq5_ff[i]  <= red4_ff[i] * red4_ff[i];
         end
         neg4_ff  <= neg3_ff;
         red5_ff  <= red4_ff;
         neg5_ff  <= neg4_ff;
         sumsq_ff <= SUMSQ_W'(sq5_ff[0]) + SUMSQ_W'(sq5_ff[1]) + SUMSQ_W'(sq5_ff[2]);
         red6_ff  <= red5_ff;
         neg6_ff  <= neg5_ff;
      end
   end

   hwn_isqrt #(
      .IN_W   (SUMSQ_W),
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .radicand  (sumsq_ff),
      .in_side   ({neg6_ff, red6_ff}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   hwn_div3 #(
      .MAG_W  (RED_W),
      .DEN_W  (ROOT_W),
      .Q_W    (Q_W),
      .SIDE_W (4)
   ) u_div3 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .num_mag   (sq_side[3*RED_W-1:0]),
      .den       (sq_root),
      .in_side   ({sq_side[SIDE_W-1 -: 3], sq_root == '0}),
      .out_valid (dv_valid),
      .quo       (dv_quo),
      .out_side  (dv_side)
   );

   // Zero length gives the unit z vector.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_side[0]) begin
               unit_ff[i] <= (i == AXIS_Z) ? U_W'(1) << FRAC_W : '0;
            end else if (dv_side[i+1]) begin
               unit_ff[i] <= U_W'(0) - U_W'(dv_quo[i]);
            end else begin
               unit_ff[i] <= U_W'(dv_quo[i]);
            end
         end
      end
   end

   assign out_valid = v7_ff;
   assign out_unit  = unit_ff;

endmodule

[rtl/hwn_merge.sv]
// Merge of the lane unit normals: summing tree and sign split.
module hwn_merge #(
   parameter int FRAC_W = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     en,
   input  logic                                     in_valid,
   input  logic [hwn_pkg::NUM_LANES-1:0][2:0][FRAC_W+1:0] in_unit,
   output logic                                     out_valid,
   output logic [2:0][FRAC_W+3:0]                   out_mag,
   output logic [2:0]                               out_neg
);
   import hwn_pkg::*;

   localparam int W   = FRAC_W + 2;
   localparam int GRP = NUM_LANES / 2;
   localparam int H_W = W + 2;
   localparam int S_W = W + 3;
   localparam int M_W = W + 2;

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [H_W-1:0]   half_in [2][3];
   logic signed [H_W-1:0]   half_ff [2][3];
   logic signed [S_W-1:0]   tot_ff  [3];
   logic [2:0][M_W-1:0]     mag_ff;
   logic [2:0]              neg_ff;

   always_comb begin
      for (int g = 0; g < 2; g++) begin
         for (int a = 0; a < 3; a++) begin
            half_in[g][a] = '0;
            for (int l = 0; l < GRP; l++) begin
               half_in[g][a] = half_in[g][a] + H_W'($signed(in_unit[g*GRP+l][a]));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         half_ff <= half_in;
         for (int a = 0; a < 3; a++) begin
            tot_ff[a] <= S_W'(half_ff[0][a]) + S_W'(half_ff[1][a]);
            neg_ff[a] <= tot_ff[a][S_W-1];
            mag_ff[a] <= tot_ff[a][S_W-1] ? M_W'(-tot_ff[a]) : M_W'(tot_ff[a]);
         end
      end
   end

   assign out_valid = v3_ff;
   assign out_mag   = mag_ff;
   assign out_neg   = neg_ff;

endmodule

[rtl/height_window_to_normal_rgb_core.sv]
// Height window to normal RGB core: slopes, eight normalizing lanes, merge, final normalize, byte map.
//
// Usage:
//   req_* carries one 3x3 window of 16-bit heights per transaction (valid/ready).
//   rsp_* returns the RGB byte triple of the merged normal (valid/ready).
//   csr_wr_en/csr_wr_data load slope_scale (unsigned Q8.24);
//   write it only while no transaction is in flight.
//   Throughput: one transaction per cycle while req_ready is high.
//   The latency is set mainly by the two normalizers in series (lane, then
//   final), each with a 31-stage square root and a NORM_FRACTION_BITS+2 stage
//   divider.
//   The pipeline advances as a whole; it holds only when the output register
//   is full, unaccepted, and another result arrives behind it. Bubbles drain
//   and new transactions enter while a finished result waits.
//   Reset clears all valid flags and sets slope_scale to 1.0.
module height_window_to_normal_rgb_core #(
   parameter int NORM_FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  hwn_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output hwn_pkg::rsp_data_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data
);
   import hwn_pkg::*;

   localparam int P   = NORM_FRACTION_BITS;
   localparam int U_W = P + 2;
   localparam int M_W = P + 4;

   logic [SCALE_W-1:0]                   scale_ff;
   logic                                 adv;
   logic                                 va_ff, vb_ff;
   logic [NUM_LANES-1:0][HEIGHT_W-1:0]   nb_height;
   logic [NUM_LANES-1:0][HEIGHT_W-1:0]   dmag_ff;
   logic [NUM_LANES-1:0]                 dneg_ff;
   logic [NUM_LANES-1:0][SLOPE_W-1:0]    slope_ff;
   logic [NUM_LANES-1:0]                 sneg_ff;
   logic [NUM_LANES-1:0][2:0][SLOPE_W-1:0] lane_mag;
   logic [NUM_LANES-1:0][2:0]            lane_neg;
   logic [NUM_LANES-1:0]                 lane_valid;
   logic [NUM_LANES-1:0][2:0][U_W-1:0]   lane_unit;
   logic                                 mg_valid;
   logic [2:0][M_W-1:0]                  mg_mag;
   logic [2:0]                           mg_neg;
   logic                                 fin_valid;
   logic [2:0][U_W-1:0]                  fin_unit;
   logic                                 rsp_valid_ff;
   rsp_data_type                         rsp_data_ff;
   rsp_data_type                         rsp_data_in;

   function automatic logic [BYTE_W-1:0] map_xy(input logic [U_W-1:0] v);
      logic signed [U_W:0]    a;
      logic signed [U_W+9:0]  ta;
      logic signed [U_W+9:0]  t;
      logic [U_W+9:0]         b;
      a  = $signed({v[U_W-1], v}) + $signed((U_W+1)'(1) << P);
      ta = (U_W+10)'(a);
      t  = (ta <<< 8) - ta;
      b  = (U_W+10)'((t + ((U_W+10)'(1) << P)) >>> (P + 1));
      if (t[U_W+9]) begin
         return '0;
      end else if (b > (U_W+10)'(255)) begin
         return 8'hFF;
      end
      return b[BYTE_W-1:0];
   endfunction

   function automatic logic [BYTE_W-1:0] map_z(input logic [U_W-1:0] v);
      logic signed [U_W+9:0]  tv;
      logic signed [U_W+9:0]  t;
      logic [U_W+9:0]         b;
      tv = (U_W+10)'($signed(v));
      t  = (tv <<< 8) - tv;
      b  = (U_W+10)'((t + ((U_W+10)'(1) << (P - 1))) >>> P);
      if (t[U_W+9]) begin
         return '0;
      end else if (b > (U_W+10)'(255)) begin
         return 8'hFF;
      end
      return b[BYTE_W-1:0];
   endfunction

   assign adv       = !(rsp_valid_ff && !rsp_ready && fin_valid);
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   always_comb begin
      nb_height[NB_W]  = req_data.west_height;
      nb_height[NB_E]  = req_data.east_height;
      nb_height[NB_N]  = req_data.north_height;
      nb_height[NB_S]  = req_data.south_height;
      nb_height[NB_NW] = req_data.northwest_height;
      nb_height[NB_NE] = req_data.northeast_height;
      nb_height[NB_SW] = req_data.southwest_height;
      nb_height[NB_SE] = req_data.southeast_height;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= req_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int n = 0; n < NUM_LANES; n++) begin
            dneg_ff[n]  <= nb_height[n] < req_data.center_height;
            dmag_ff[n]  <= (nb_height[n] < req_data.center_height) ?
                           req_data.center_height - nb_height[n] :
                           nb_height[n] - req_data.center_height;
            slope_ff[n] <= dmag_ff[n] * scale_ff;
            sneg_ff[n]  <= dneg_ff[n];
         end
      end
   end

   always_comb begin
      lane_mag = '0;
      lane_neg = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
         lane_mag[l][AXIS_Z] = (l < 4) ? Z_EDGE : Z_DIAG;
      end
      lane_mag[0][AXIS_X] = slope_ff[NB_W];
      lane_neg[0][AXIS_X] = sneg_ff[NB_W];
      lane_mag[1][AXIS_Y] = slope_ff[NB_N];
      lane_neg[1][AXIS_Y] = !sneg_ff[NB_N];
      lane_mag[2][AXIS_X] = slope_ff[NB_E];
      lane_neg[2][AXIS_X] = !sneg_ff[NB_E];
      lane_mag[3][AXIS_Y] = slope_ff[NB_S];
      lane_neg[3][AXIS_Y] = sneg_ff[NB_S];
      lane_mag[4][AXIS_X] = slope_ff[NB_NW];
      lane_neg[4][AXIS_X] = sneg_ff[NB_NW];
      lane_mag[4][AXIS_Y] = slope_ff[NB_NW];
      lane_neg[4][AXIS_Y] = !sneg_ff[NB_NW];
      lane_mag[5][AXIS_X] = slope_ff[NB_NE];
      lane_neg[5][AXIS_X] = !sneg_ff[NB_NE];
      lane_mag[5][AXIS_Y] = slope_ff[NB_NE];
      lane_neg[5][AXIS_Y] = !sneg_ff[NB_NE];
      lane_mag[6][AXIS_X] = slope_ff[NB_SE];
      lane_neg[6][AXIS_X] = !sneg_ff[NB_SE];
      lane_mag[6][AXIS_Y] = slope_ff[NB_SE];
      lane_neg[6][AXIS_Y] = sneg_ff[NB_SE];
      lane_mag[7][AXIS_X] = slope_ff[NB_SW];
      lane_neg[7][AXIS_X] = sneg_ff[NB_SW];
      lane_mag[7][AXIS_Y] = slope_ff[NB_SW];
      lane_neg[7][AXIS_Y] = sneg_ff[NB_SW];
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      hwn_norm #(
         .MAG_W  (SLOPE_W),
         .FRAC_W (P)
      ) u_norm (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (vb_ff),
         .in_mag    (lane_mag[l]),
         .in_neg    (lane_neg[l]),
         .out_valid (lane_valid[l]),
         .out_unit  (lane_unit[l])
      );
   end

   hwn_merge #(
      .FRAC_W (P)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (lane_valid[0]),
      .in_unit   (lane_unit),
      .out_valid (mg_valid),
      .out_mag   (mg_mag),
      .out_neg   (mg_neg)
   );

   hwn_norm #(
      .MAG_W  (M_W),
      .FRAC_W (P)
   ) u_final (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (mg_valid),
      .in_mag    (mg_mag),
      .in_neg    (mg_neg),
      .out_valid (fin_valid),
      .out_unit  (fin_unit)
   );

   always_comb begin
      rsp_data_in.red_byte   = map_xy(fin_unit[AXIS_X]);
      rsp_data_in.green_byte = map_xy(fin_unit[AXIS_Y]);
      rsp_data_in.blue_byte  = map_z(fin_unit[AXIS_Z]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready || !rsp_valid_ff) begin
         rsp_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !rsp_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while output could drain");

   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      (&lane_valid) || !(|lane_valid))
      else $error("lane valid flags diverged");

   a_scale_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> scale_ff == $past(csr_wr_data))
      else $error("slope scale write lost");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

[sim/height_window_to_normal_rgb_core_tb.sv]
// Self-checking testbench for the height window to normal RGB core.
`timescale 1ns / 1ps
module height_window_to_normal_rgb_core_tb;
   import hwn_pkg::*;

   localparam int FRAC       = 16;
   localparam int DRAIN      = 2 * FRAC + 86 + 16;
   localparam int CYCLE_MAX  = 600000;
   localparam int MAX_GAP    = 13;

   typedef longint vec3_type [3];

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_data_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_data_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [31:0]  csr_wr_data = '0;

   logic [31:0]  scale_model = SCALE_RESET;
   rsp_data_type pixel_queue [$];
   int           mismatches = 0;
   int           cycles = 0;
   int           rsp_stall = 0;
   bit           send_idle_on = 1'b1;
   bit           recv_idle_on = 1'b1;

   height_window_to_normal_rgb_core #(.NORM_FRACTION_BITS(FRAC)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic vec3_type unit_vector(vec3_type c);
      longint unsigned mag [3];
      longint unsigned m = 0, sumsq = 0, len, q;
      int k = 0;
      vec3_type u;
      for (int i = 0; i < 3; i++) begin
         mag[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
         if (mag[i] > m) m = mag[i];
      end
      while (k < 63 && (m >> k) >= 64'd1 << 30) k++;
      for (int i = 0; i < 3; i++) begin
         mag[i] >>= k;
         sumsq += mag[i] * mag[i];
      end
      len = root_floor(sumsq);
      if (len == 0) begin
         u[0] = 0;
         u[1] = 0;
         u[2] = 64'sd1 << FRAC;
         return u;
      end
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << FRAC) + len / 2) / len;
         u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      return u;
   endfunction

   function automatic logic [7:0] signed_to_byte(longint v);
      longint t = 255 * (v + (64'sd1 << FRAC));
      longint unsigned b;
      if (t < 0) return 8'd0;
      b = (longint'(t) + (64'd1 << FRAC)) >> (FRAC + 1);
      return b > 255 ? 8'd255 : b[7:0];
   endfunction

   function automatic logic [7:0] unsigned_to_byte(longint v);
      longint t = 255 * v;
      longint unsigned b;
      if (t < 0) return 8'd0;
      b = (longint'(t) + (64'd1 << (FRAC - 1))) >> FRAC;
      return b > 255 ? 8'd255 : b[7:0];
   endfunction

   function automatic rsp_data_type predict_pixel(req_data_type w, logic [31:0] scale);
      longint h0, sw, se, sn, ss, snw, sne, ssw, sse, sc;
      longint one = 64'sd1 << 24, two = 64'sd1 << 25;
      vec3_type nv [8];
      vec3_type u, acc, n;
      rsp_data_type p;
      sc  = longint'({32'd0, scale});
      h0  = w.center_height;
      sw  = (longint'(w.west_height) - h0) * sc;
      se  = (longint'(w.east_height) - h0) * sc;
      sn  = (longint'(w.north_height) - h0) * sc;
      ss  = (longint'(w.south_height) - h0) * sc;
      snw = (longint'(w.northwest_height) - h0) * sc;
      sne = (longint'(w.northeast_height) - h0) * sc;
      ssw = (longint'(w.southwest_height) - h0) * sc;
      sse = (longint'(w.southeast_height) - h0) * sc;
      nv[0] = '{sw, 0, one};
      nv[1] = '{0, -sn, one};
      nv[2] = '{-se, 0, one};
      nv[3] = '{0, ss, one};
      nv[4] = '{snw, -snw, two};
      nv[5] = '{-sne, -sne, two};
      nv[6] = '{-sse, sse, two};
      nv[7] = '{ssw, ssw, two};
      acc = '{0, 0, 0};
      for (int i = 0; i < 8; i++) begin
         u = unit_vector(nv[i]);
         for (int j = 0; j < 3; j++) acc[j] += u[j];
      end
      n = unit_vector(acc);
      p.red_byte   = signed_to_byte(n[0]);
      p.green_byte = signed_to_byte(n[1]);
      p.blue_byte  = unsigned_to_byte(n[2]);
      return p;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(negedge clock) rsp_ready <= (rsp_stall == 0) && !reset;

   always @(posedge clock) begin
      rsp_data_type want;
      if (rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pixel %h", rsp_data);
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_data.red_byte !== want.red_byte || rsp_data.green_byte !== want.green_byte
                || rsp_data.blue_byte !== want.blue_byte) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pixel mismatch: expected r%0d g%0d b%0d got r%0d g%0d b%0d",
                     want.red_byte, want.green_byte, want.blue_byte,
                     rsp_data.red_byte, rsp_data.green_byte, rsp_data.blue_byte);
            end
         end
         rsp_stall = recv_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
      end
   end

   task automatic send_window(req_data_type w);
      int gap = send_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      pixel_queue = {pixel_queue, predict_pixel(w, scale_model)};
   endtask

   task automatic drain_pipe();
      @(negedge clock) req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_scale(logic [31:0] v);
      drain_pipe();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock) csr_wr_en <= 1'b0;
      scale_model = v;
   endtask

   function automatic req_data_type flat_window(logic [15:0] c, logic [15:0] n);
      req_data_type w;
      w = '{c, n, n, n, n, n, n, n, n};
      return w;
   endfunction

   function automatic req_data_type random_window();
      req_data_type w;
      logic [15:0] c = 16'($urandom);
      int spread;
      if ($urandom_range(0, 3) == 0)
         return req_data_type'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      spread = 1 << $urandom_range(0, 12);
      w = flat_window(c, c);
      w.west_height      = 16'(c + $urandom_range(0, 2 * spread) - spread);
      w.east_height      = 16'(c + $urandom_range(0, 2 * spread) - spread);
      w.north_height     = 16'(c + $urandom_range(0, 2 * spread) - spread);
      w.south_height     = 16'(c + $urandom_range(0, 2 * spread) - spread);
      w.northwest_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
      w.northeast_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
      w.southwest_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
      w.southeast_height = 16'(c + $urandom_range(0, 2 * spread) - spread);
      return w;
   endfunction

   task automatic test_flat_and_extremes();
      req_data_type w;
      send_window(flat_window(16'd0, 16'd0));
      send_window(flat_window(16'hFFFF, 16'hFFFF));
      send_window(flat_window(16'd0, 16'hFFFF));
      send_window(flat_window(16'hFFFF, 16'd0));
      for (int i = 0; i < 8; i++) begin
         w = flat_window(16'h8000, 16'h8000);
         w[i*16 +: 16] = 16'hFFFF;
         send_window(w);
         w[i*16 +: 16] = 16'd0;
         send_window(w);
      end
   endtask

   task automatic test_scale_extremes();
      write_scale(32'd0);
      send_window(flat_window(16'd0, 16'hFFFF));
      send_window(random_window());
      write_scale(32'hFFFF_FFFF);
      send_window(flat_window(16'd0, 16'hFFFF));
      send_window(flat_window(16'h8000, 16'h8001));
      send_window(req_data_type'({16'h8000, 16'h8001, 16'h8000, 16'h8000, 16'h8000,
                                  16'h8000, 16'h8000, 16'h8000, 16'hFFFF}));
      write_scale(32'd1);
      send_window(flat_window(16'h0, 16'h1));
      send_window(flat_window(16'hFFFF, 16'h0));
   endtask

   task automatic test_random_windows();
      logic [31:0] scales [6];
      scales = '{SCALE_RESET, 32'd0, 32'hFFFF_FFFF, $urandom, $urandom_range(0, 32'h0400_0000),
                 $urandom_range(0, 32'h0010_0000)};
      for (int s = 0; s < 6; s++) begin
         write_scale(scales[s]);
         for (int i = 0; i < 220; i++) begin
            if (i % 70 == 0) begin
               send_idle_on = (i != 70);
               recv_idle_on = (i != 140);
            end
            send_window(random_window());
         end
      end
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_flat_and_extremes();
      test_scale_extremes();
      test_random_windows();
      drain_pipe();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
rtl/hwn_pkg.sv
rtl/hwn_isqrt.sv
rtl/hwn_div3.sv
rtl/hwn_norm.sv
rtl/hwn_merge.sv
rtl/height_window_to_normal_rgb_core.sv
sim/height_window_to_normal_rgb_core_tb.sv
